// ----- src/boi_pkg.sv -----
package boi_pkg;

    localparam int CORDIC_STEPS_DEF  = 16;
    localparam int POS_FRAC_BITS_DEF = 16;

    // 2^30 / (2*pi), radians to binary angle
    localparam logic [27:0] RAD_TO_BAM = 28'd170891319;
    // CORDIC start value, pre-scaled by the converged gain (Q4.30)
    localparam logic signed [33:0] CORDIC_START = 34'sd652032874;

    localparam logic [15:0] SPEED_GAIN_RST      = 16'd18350;
    localparam logic [23:0] STEER_GAIN_RST      = 24'd9073;
    localparam logic [15:0] WHEELBASE_RST       = 16'd452;
    localparam logic [15:0] TIME_STEP_RST       = 16'd3277;
    localparam logic [31:0] INITIAL_HEADING_RST = 32'd1073196363;

    localparam logic [2:0] REG_SPEED_GAIN      = 3'd0;
    localparam logic [2:0] REG_STEER_GAIN      = 3'd1;
    localparam logic [2:0] REG_WHEELBASE       = 3'd2;
    localparam logic [2:0] REG_TIME_STEP       = 3'd3;
    localparam logic [2:0] REG_INITIAL_HEADING = 3'd4;

    // atan(2^-i) in binary angle units
    function automatic logic [29:0] atan_bam(input logic [4:0] idx);
        logic [29:0] r;
        case (idx)
            5'd0:  r = 30'd536870912;
            5'd1:  r = 30'd316933406;
            5'd2:  r = 30'd167458907;
            5'd3:  r = 30'd85004756;
            5'd4:  r = 30'd42667331;
            5'd5:  r = 30'd21354465;
            5'd6:  r = 30'd10679838;
            5'd7:  r = 30'd5340245;
            5'd8:  r = 30'd2670163;
            5'd9:  r = 30'd1335087;
            5'd10: r = 30'd667544;
            5'd11: r = 30'd333772;
            5'd12: r = 30'd166886;
            5'd13: r = 30'd83443;
            5'd14: r = 30'd41722;
            5'd15: r = 30'd20861;
            5'd16: r = 30'd10430;
            5'd17: r = 30'd5215;
            5'd18: r = 30'd2608;
            5'd19: r = 30'd1304;
            5'd20: r = 30'd652;
            5'd21: r = 30'd326;
            5'd22: r = 30'd163;
            5'd23: r = 30'd81;
            5'd24: r = 30'd41;
            5'd25: r = 30'd20;
            5'd26: r = 30'd10;
            5'd27: r = 30'd5;
            5'd28: r = 30'd3;
            5'd29: r = 30'd1;
            5'd30: r = 30'd1;
            default: r = 30'd0;
        endcase
        return r;
    endfunction

endpackage

// ----- src/bicycle_odometry_integrator_top.sv -----
// Kinematic bicycle odometry integrator.
// Slave stream (i_s_axis_*): one beat per measurement, raw speed and raw
// steering-wheel angle. Master stream (o_m_axis_*): one beat per input
// with updated x, y, heading, velocity and yaw rate.
// APB port: speed_gain, steer_gain, wheelbase, time_step, initial_heading
// at byte addresses 0, 4, 8, 12, 16; pready is always high. Write only
// while the block is idle. A written initial_heading is only read back.
// Operation: one item at a time. Each item runs 11 multiplies in a
// bit-serial shift-add unit (one multiplier bit per cycle), two CORDIC
// runs of CORDIC_STEPS steps and a restoring divide (skipped for a zero
// divisor), with a sequencer step before each. The next item is accepted
// as soon as the previous one is done; its result waits in the output
// register while the receiver stalls, and the block holds its last step
// until that register is free.
// Reset: registers take their defaults, x and y go to zero and the heading
// to the default initial heading; no output is pending.
module bicycle_odometry_integrator_top
    import boi_pkg::*;
#(
    parameter int CORDIC_STEPS  = CORDIC_STEPS_DEF,
    parameter int POS_FRAC_BITS = POS_FRAC_BITS_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    input  logic [31:0]  i_s_axis_tdata,   // speed_raw[15:0], steer_raw[31:16]
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    output logic [127:0] o_m_axis_tdata,   // x_pos, y_pos, heading_out, velocity, yaw_rate
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [4:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    localparam int SH_POS = 54 - POS_FRAC_BITS;
    localparam int CNT_W  = $clog2(CORDIC_STEPS + 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEQ,
        ST_MUL,
        ST_CORDIC,
        ST_DIV
    } t_state;

    typedef enum logic [3:0] {
        PH_SPEED, PH_STEER, PH_WHEEL_K, PH_WHEEL_COS, PH_NUM, PH_DEN, PH_DIVIDE,
        PH_YAW, PH_YAW_TS, PH_YAW_K, PH_HEAD_COS, PH_X_V, PH_X_TS, PH_Y_V, PH_Y_TS,
        PH_COMMIT
    } t_phase;

    t_state r_state;
    t_phase r_phase;

    logic [15:0] r_speed_gain, r_wheelbase, r_time_step;
    logic [23:0] r_steer_gain;
    logic [31:0] r_initial_heading;

    logic signed [15:0] r_speed, r_steer, r_v;
    logic signed [31:0] r_x, r_y, r_x_new, r_yaw;
    logic [31:0]        r_heading, r_dh;

    // bit-serial multiplier
    logic signed [63:0] r_acc, r_ma;
    logic [27:0]        r_mb;
    logic [4:0]         r_mcnt;
    logic               r_msgn;

    // CORDIC
    logic signed [33:0] r_cx, r_cy, r_cs, r_ss;
    logic signed [32:0] r_cz;
    logic [CNT_W-1:0]   r_ccnt;
    logic               r_cflip;

    // divider
    logic signed [63:0] r_num;
    logic [63:0]        r_rem, r_dvd, r_dvs, r_q;
    logic [6:0]         r_dcnt;
    logic               r_qneg;

    logic         r_m_valid;
    logic [127:0] r_m_data;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] a);
        logic signed [31:0] r;
        if (a > 64'sd2147483647)       r = 32'sh7fff_ffff;
        else if (a < -64'sd2147483648) r = 32'sh8000_0000;
        else                           r = a[31:0];
        return r;
    endfunction

    // fold into [-pi/2, pi/2]
    function automatic logic [33:0] fold(input logic [31:0] a);
        logic signed [32:0] z;
        logic               f;
        z = {a[31], a};
        f = 1'b0;
        if (z > 33'sd1073741824) begin
            z = z - 33'sd2147483648;
            f = 1'b1;
        end else if (z < -33'sd1073741824) begin
            z = z + 33'sd2147483648;
            f = 1'b1;
        end
        return {f, z};
    endfunction

    // multiplier step
    logic               mul_last;
    logic signed [63:0] mul_acc;
    assign mul_last = (r_mcnt == 5'd1);
    always_comb begin
        mul_acc = r_acc;
        if (r_mb[0]) mul_acc = (mul_last && r_msgn) ? r_acc - r_ma : r_acc + r_ma;
    end

    // CORDIC step
    logic [4:0]         c_idx;
    logic signed [33:0] c_nx, c_ny, c_fx, c_fy;
    logic signed [32:0] c_nz, c_atan;
    logic               c_last;
    assign c_idx  = 5'(r_ccnt);
    assign c_atan = 33'(atan_bam(c_idx));
    assign c_last = (r_ccnt == CNT_W'(CORDIC_STEPS - 1));
    always_comb begin
        if (!r_cz[32]) begin
            c_nx = r_cx - (r_cy >>> c_idx);
            c_ny = r_cy + (r_cx >>> c_idx);
            c_nz = r_cz - c_atan;
        end else begin
            c_nx = r_cx + (r_cy >>> c_idx);
            c_ny = r_cy - (r_cx >>> c_idx);
            c_nz = r_cz + c_atan;
        end
        c_fx = r_cflip ? -c_nx : c_nx;
        c_fy = r_cflip ? -c_ny : c_ny;
    end

    // divider step
    logic [63:0] d_sh;
    logic        d_ge;
    assign d_sh = {r_rem[62:0], r_dvd[63]};
    assign d_ge = (d_sh >= r_dvs);

    // per-phase arithmetic on finished results
    logic signed [63:0] v_rnd, pos_rnd, pos_sum, num_sh;
    logic signed [15:0] v_sat;
    logic [63:0]        wheel_rnd, dh_rnd;
    logic signed [31:0] yaw_q;
    logic signed [32:0] yaw_rnd;
    logic signed [15:0] yaw_out;
    logic [33:0]        fold_wheel, fold_head;

    always_comb begin
        v_rnd = (r_acc + 64'sd32768) >>> 16;
        if (v_rnd > 64'sd32767)       v_sat = 16'sh7fff;
        else if (v_rnd < -64'sd32768) v_sat = 16'sh8000;
        else                          v_sat = v_rnd[15:0];
        wheel_rnd = 64'(r_acc) + (64'd1 << 25);
        dh_rnd    = 64'(r_acc) + (64'd1 << 29);
        pos_rnd   = (r_acc + (64'sd1 <<< (SH_POS - 1))) >>> SH_POS;
        num_sh    = r_num <<< 16;
        if (r_qneg) yaw_q = (r_q > 64'd2147483648) ? 32'sh8000_0000 : 32'(-r_q);
        else        yaw_q = (r_q > 64'd2147483647) ? 32'sh7fff_ffff : r_q[31:0];
        yaw_rnd = (33'(r_yaw) + 33'sd128) >>> 8;
        if (yaw_rnd > 33'sd32767)       yaw_out = 16'sh7fff;
        else if (yaw_rnd < -33'sd32768) yaw_out = 16'sh8000;
        else                            yaw_out = yaw_rnd[15:0];
        fold_wheel = fold(wheel_rnd[57:26]);
        fold_head  = fold(r_heading);
        pos_sum = 64'(r_phase == PH_COMMIT ? r_y : r_x) + pos_rnd;
    end

    logic s_acc, m_acc, cfg_wr;
    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign s_acc  = i_s_axis_tvalid && o_s_axis_tready;
    assign m_acc  = r_m_valid && i_m_axis_tready;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign pready = 1'b1;
    assign o_m_axis_tvalid = r_m_valid;
    assign o_m_axis_tdata  = r_m_data;

    always_comb begin
        case (paddr[4:2])
            REG_SPEED_GAIN:      prdata = {16'd0, r_speed_gain};
            REG_STEER_GAIN:      prdata = {8'd0, r_steer_gain};
            REG_WHEELBASE:       prdata = {16'd0, r_wheelbase};
            REG_TIME_STEP:       prdata = {16'd0, r_time_step};
            REG_INITIAL_HEADING: prdata = r_initial_heading;
            default:             prdata = 32'd0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state           <= ST_IDLE;
            r_phase           <= PH_SPEED;
            r_speed_gain      <= SPEED_GAIN_RST;
            r_steer_gain      <= STEER_GAIN_RST;
            r_wheelbase       <= WHEELBASE_RST;
            r_time_step       <= TIME_STEP_RST;
            r_initial_heading <= INITIAL_HEADING_RST;
            r_x               <= '0;
            r_y               <= '0;
            r_heading         <= INITIAL_HEADING_RST;
            r_m_valid         <= 1'b0;
        end else begin
            if (cfg_wr) begin
                case (paddr[4:2])
                    REG_SPEED_GAIN:      r_speed_gain      <= pwdata[15:0];
                    REG_STEER_GAIN:      r_steer_gain      <= pwdata[23:0];
                    REG_WHEELBASE:       r_wheelbase       <= pwdata[15:0];
                    REG_TIME_STEP:       r_time_step       <= pwdata[15:0];
                    REG_INITIAL_HEADING: r_initial_heading <= pwdata;
                    default: ;
                endcase
            end
            if (m_acc) r_m_valid <= 1'b0;

            case (r_state)
                ST_IDLE: begin
                    if (s_acc) begin
                        r_speed <= i_s_axis_tdata[15:0];
                        r_steer <= i_s_axis_tdata[31:16];
                        r_phase <= PH_SPEED;
                        r_state <= ST_SEQ;
                    end
                end
                ST_MUL: begin
                    r_acc  <= mul_acc;
                    r_ma   <= r_ma <<< 1;
                    r_mb   <= r_mb >> 1;
                    r_mcnt <= r_mcnt - 5'd1;
                    if (mul_last) r_state <= ST_SEQ;
                end
                ST_CORDIC: begin
                    r_cx   <= c_last ? c_fx : c_nx;
                    r_cy   <= c_last ? c_fy : c_ny;
                    r_cz   <= c_nz;
                    r_ccnt <= r_ccnt + CNT_W'(1);
                    if (c_last) r_state <= ST_SEQ;
                end
                ST_DIV: begin
                    r_rem  <= d_ge ? d_sh - r_dvs : d_sh;
                    r_q    <= {r_q[62:0], d_ge};
                    r_dvd  <= r_dvd << 1;
                    r_dcnt <= r_dcnt - 7'd1;
                    if (r_dcnt == 7'd1) r_state <= ST_SEQ;
                end
                ST_SEQ: begin
                    // consume the last result, launch the next operation
                    r_phase <= t_phase'(r_phase + 4'd1);
                    r_state <= ST_MUL;
                    r_acc   <= '0;
                    r_msgn  <= 1'b0;
                    r_mcnt  <= 5'd16;
                    r_ccnt  <= '0;
                    r_cx    <= CORDIC_START;
                    r_cy    <= '0;
                    case (r_phase)
                        PH_SPEED: begin
                            r_ma <= 64'(r_speed);
                            r_mb <= 28'(r_speed_gain);
                        end
                        PH_STEER: begin
                            r_v    <= v_sat;
                            r_ma   <= 64'(r_steer);
                            r_mb   <= 28'(r_steer_gain);
                            r_mcnt <= 5'd24;
                        end
                        PH_WHEEL_K: begin
                            r_ma   <= r_acc;
                            r_mb   <= RAD_TO_BAM;
                            r_mcnt <= 5'd28;
                        end
                        PH_WHEEL_COS: begin
                            r_cflip <= fold_wheel[33];
                            r_cz    <= fold_wheel[32:0];
                            r_state <= ST_CORDIC;
                        end
                        PH_NUM: begin
                            r_cs   <= r_cx;
                            r_ss   <= r_cy;
                            r_ma   <= 64'(r_cy);
                            r_mb   <= 28'(r_v);
                            r_msgn <= 1'b1;
                        end
                        PH_DEN: begin
                            r_num <= r_acc;
                            r_ma  <= 64'(r_cs);
                            r_mb  <= 28'(r_wheelbase);
                        end
                        PH_DIVIDE: begin
                            if (r_acc == 64'sd0) begin
                                // zero divisor: saturate to the numerator's sign
                                if (r_num > 64'sd0)      r_yaw <= 32'sh7fff_ffff;
                                else if (r_num < 64'sd0) r_yaw <= 32'sh8000_0000;
                                else                     r_yaw <= '0;
                                r_phase <= PH_YAW_TS;
                                r_state <= ST_SEQ;
                            end else begin
                                r_dvd   <= num_sh[63] ? 64'(-num_sh) : 64'(num_sh);
                                r_dvs   <= r_acc[63] ? 64'(-r_acc) : 64'(r_acc);
                                r_qneg  <= num_sh[63] ^ r_acc[63];
                                r_rem   <= '0;
                                r_q     <= '0;
                                r_dcnt  <= 7'd64;
                                r_state <= ST_DIV;
                            end
                        end
                        PH_YAW: begin
                            r_yaw   <= yaw_q;
                            r_state <= ST_SEQ;
                        end
                        PH_YAW_TS: begin
                            r_ma <= 64'(r_yaw);
                            r_mb <= 28'(r_time_step);
                        end
                        PH_YAW_K: begin
                            r_ma   <= r_acc;
                            r_mb   <= RAD_TO_BAM;
                            r_mcnt <= 5'd28;
                        end
                        PH_HEAD_COS: begin
                            r_dh    <= dh_rnd[61:30];
                            r_cflip <= fold_head[33];
                            r_cz    <= fold_head[32:0];
                            r_state <= ST_CORDIC;
                        end
                        PH_X_V: begin
                            r_ss   <= r_cy;
                            r_ma   <= 64'(r_cx);
                            r_mb   <= 28'(r_v);
                            r_msgn <= 1'b1;
                        end
                        PH_X_TS, PH_Y_TS: begin
                            r_ma <= r_acc;
                            r_mb <= 28'(r_time_step);
                        end
                        PH_Y_V: begin
                            r_x_new <= sat32(pos_sum);
                            r_ma    <= 64'(r_ss);
                            r_mb    <= 28'(r_v);
                            r_msgn  <= 1'b1;
                        end
                        default: begin
                            // commit; hold while the previous beat is still pending
                            r_phase <= PH_COMMIT;
                            r_state <= ST_SEQ;
                            if (!r_m_valid || i_m_axis_tready) begin
                                r_x       <= r_x_new;
                                r_y       <= sat32(pos_sum);
                                r_heading <= r_heading + r_dh;
                                r_m_valid <= 1'b1;
                                r_m_data  <= {yaw_out, r_v, r_heading + r_dh,
                                              sat32(pos_sum), r_x_new};
                                r_state   <= ST_IDLE;
                            end
                        end
                    endcase
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    a_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_acc |=> (r_state == ST_SEQ) && (r_phase == PH_SPEED))
        else $error("accepted beat did not start the sequence");
    a_mul_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_MUL) |-> (r_mcnt != 5'd0))
        else $error("multiplier running with empty count");
    a_div_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV) |-> (r_dcnt != 7'd0))
        else $error("divider running with empty count");
    a_out_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_m_valid && !$past(r_m_valid)) |-> ($past(r_phase) == PH_COMMIT))
        else $error("output raised outside the commit step");

endmodule
